// File: hdl/lgsf_pkg.sv
// Shared constants, types and a helper function for the linear gradient span fetch unit.
package lgsf_pkg;

    // Table and span sizing; TABLE_SIZE must be a power of two
    localparam int TABLE_SIZE    = 256;
    localparam int MAX_SPAN      = 64;
    localparam int FRACTION_BITS = 24;

    // Field widths
    localparam int POS_W     = 40;
    localparam int COORD_W   = 12;
    localparam int LEN_W     = 7;
    localparam int COLOR_W   = 32;
    localparam int ENTRY_W   = 8;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 40;

    // Derived datapath widths
    localparam int IDX_W    = $clog2(TABLE_SIZE);
    localparam int CNT_W    = $clog2(MAX_SPAN + 1);
    localparam int PROD_W   = POS_W + COORD_W + 2;
    localparam int SUM_W    = PROD_W + 1;
    localparam int V_W      = POS_W + IDX_W;
    localparam int MAG_W    = V_W - FRACTION_BITS;
    localparam int REFL_LIM = 2 * TABLE_SIZE - 1;
    localparam int REFL_W   = IDX_W + 1;
    localparam int NDIG     = (MAG_W + REFL_W - 1) / REFL_W;
    localparam int DSUM_W   = REFL_W + $clog2(NDIG + 1);
    localparam int PIPE_N   = 5;

    // Item opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_SPAN = 1'b1;

    // Spread modes (unused code acts as pad)
    localparam logic [MODE_W-1:0] SPREAD_PAD     = 2'd0;
    localparam logic [MODE_W-1:0] SPREAD_REFLECT = 2'd1;
    localparam logic [MODE_W-1:0] SPREAD_REPEAT  = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_X      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_Y      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_OFFS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPREAD_MODE = 3'd3;

    typedef struct packed {
        logic               opcode;
        logic [ENTRY_W-1:0] entry_index;
        logic [COLOR_W-1:0] entry_color;
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [LEN_W-1:0]   span_length;
    } t_item;

    typedef struct packed {
        logic [COLOR_W-1:0] pixel_color;
        logic               last_pixel;
    } t_result;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_INIT,
        ST_RUN,
        ST_DRAIN
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic load_prod;
        logic load_sum;
        logic init;
        logic step;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic len_zero;
        logic cnt_last;
        logic pipe_empty;
    } t_dp_stat;

    // Magnitude modulo (2*TABLE_SIZE-1): digits of REFL_W bits sum congruently
    function automatic logic [REFL_W-1:0] refl_rem(input logic [MAG_W-1:0] mag);
        logic [NDIG*REFL_W-1:0] ext;
        logic [DSUM_W-1:0]      dsum;
        logic [REFL_W:0]        fold;
        ext  = (NDIG*REFL_W)'(mag);
        dsum = '0;
        for (int k = 0; k < NDIG; k++) begin
            dsum = dsum + DSUM_W'(ext[k*REFL_W +: REFL_W]);
        end
        fold = (REFL_W+1)'(dsum[REFL_W-1:0]) + (REFL_W+1)'(dsum[DSUM_W-1:REFL_W]);
        if (fold >= (REFL_W+1)'(REFL_LIM)) begin
            fold = fold - (REFL_W+1)'(REFL_LIM);
        end
        return fold[REFL_W-1:0];
    endfunction

endpackage

// File: hdl/lgsf_ctrl.sv
// Sequencing state machine for span setup, pixel issue and pipeline drain.
module lgsf_ctrl
    import lgsf_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  logic     i_span,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_busy
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start && i_span) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL:  n_state = ST_SUM;
            ST_SUM:  n_state = ST_INIT;
            ST_INIT: begin
                n_state = i_stat.len_zero ? ST_IDLE : ST_RUN;
            end
            ST_RUN: begin
                if (i_stat.cnt_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (i_stat.pipe_empty) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_busy       = 1'b0;
                o_cmd.capture = i_start;
            end
            ST_MUL:   o_cmd.load_prod = 1'b1;
            ST_SUM:   o_cmd.load_sum  = 1'b1;
            ST_INIT:  o_cmd.init      = 1'b1;
            ST_RUN:   o_cmd.step      = 1'b1;
            ST_DRAIN: o_cmd           = '0;
            default:  o_busy          = 1'b1;
        endcase
    end

    // Nothing is in flight while the unit is free
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> i_stat.pipe_empty)
        else $error("pixel pipeline not empty while idle");

    // A span always issues at least one pixel once it runs
    a_run_from_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && !$past(r_state == ST_RUN)) |-> $past(!i_stat.len_zero))
        else $error("run entered for an empty span");

endmodule

// File: hdl/lgsf_dpath.sv
// Position arithmetic, index mapping pipeline and color table.
module lgsf_dpath
    import lgsf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  t_item                i_item,
    input  t_dp_cmd              i_cmd,
    output t_dp_stat             o_stat,
    output t_result              o_result,
    output logic                 o_strobe
);

    localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
    localparam logic [V_W-1:0]          V_HALF  = V_W'(1) << (FRACTION_BITS - 1);

    // Configuration registers
    logic signed [POS_W-1:0]  r_gain_x;
    logic signed [POS_W-1:0]  r_gain_y;
    logic signed [POS_W-1:0]  r_offs;
    logic [MODE_W-1:0]        r_mode;

    // Span setup
    logic [COORD_W-1:0]       r_x;
    logic [COORD_W-1:0]       r_y;
    logic [LEN_W-1:0]         r_len;
    logic signed [PROD_W-1:0] r_prod_x;
    logic signed [PROD_W-1:0] r_prod_y;
    logic signed [SUM_W-1:0]  r_sum;
    logic signed [POS_W-1:0]  r_acc;
    logic [CNT_W-1:0]         r_cnt;

    // Pixel pipeline
    logic [PIPE_N-1:0]        r_vld;
    logic [PIPE_N-1:0]        r_last;
    logic signed [V_W-1:0]    r_v;
    logic                     r_neg2;
    logic [MAG_W-1:0]         r_mag2;
    logic                     r_neg3;
    logic [MAG_W-1:0]         r_mag3;
    logic [REFL_W-1:0]        r_rem3;
    logic [IDX_W-1:0]         r_addr;
    logic [COLOR_W-1:0]       r_rdata;
    logic [COLOR_W-1:0]       r_table [TABLE_SIZE];

    logic signed [PROD_W-1:0] prod_x;
    logic signed [PROD_W-1:0] prod_y;
    logic signed [SUM_W-1:0]  half;
    logic signed [POS_W-1:0]  init_pos;
    logic [POS_W:0]           step_sum;
    logic signed [POS_W-1:0]  step_pos;
    logic signed [V_W-1:0]    acc_ext;
    logic [V_W-1:0]           v_next;
    logic [V_W-1:0]           v_neg;
    logic [MAG_W-1:0]         mag_next;
    logic [MAG_W-1:0]         mag_neg;
    logic [REFL_W-1:0]        refl_a;
    logic [REFL_W-1:0]        refl_b;
    logic [IDX_W-1:0]         addr_next;
    logic [CNT_W-1:0]         len_clamped;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_x <= '0;
            r_gain_y <= '0;
            r_offs   <= '0;
            r_mode   <= SPREAD_PAD;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_GAIN_X:      r_gain_x <= i_cfg_data[POS_W-1:0];
                CFG_GAIN_Y:      r_gain_y <= i_cfg_data[POS_W-1:0];
                CFG_ORIGIN_OFFS: r_offs   <= i_cfg_data[POS_W-1:0];
                CFG_SPREAD_MODE: r_mode   <= i_cfg_data[MODE_W-1:0];
                default:         r_mode   <= r_mode;
            endcase
        end
    end

    // Start position: gain*(2c+1) products, then sum, then floor halve and saturate
    assign prod_x = PROD_W'(r_gain_x) * PROD_W'($signed({1'b0, r_x, 1'b1}));
    assign prod_y = PROD_W'(r_gain_y) * PROD_W'($signed({1'b0, r_y, 1'b1}));
    assign half   = r_sum >>> 1;

    always_comb begin
        if (half > SUM_W'(POS_MAX)) begin
            init_pos = POS_MAX;
        end else if (half < SUM_W'(POS_MIN)) begin
            init_pos = POS_MIN;
        end else begin
            init_pos = half[POS_W-1:0];
        end
    end

    // Per pixel step with saturation
    assign step_sum = (POS_W+1)'(r_acc) + (POS_W+1)'(r_gain_x);
    assign step_pos = (step_sum[POS_W] != step_sum[POS_W-1])
                    ? (step_sum[POS_W] ? POS_MIN : POS_MAX)
                    : step_sum[POS_W-1:0];

    // Clamp span length
    assign len_clamped = (int'(r_len) > MAX_SPAN) ? CNT_W'(MAX_SPAN) : CNT_W'(r_len);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_x   <= i_item.start_x;
            r_y   <= i_item.start_y;
            r_len <= i_item.span_length;
        end
        if (i_cmd.load_prod) begin
            r_prod_x <= prod_x;
            r_prod_y <= prod_y;
        end
        if (i_cmd.load_sum) begin
            r_sum <= SUM_W'(r_prod_x) + SUM_W'(r_prod_y) + (SUM_W'(r_offs) <<< 1);
        end
    end

    // Position accumulator and pixel counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_cnt <= '0;
        end else if (i_cmd.init) begin
            r_acc <= init_pos;
            r_cnt <= len_clamped;
        end else if (i_cmd.step) begin
            r_acc <= step_pos;
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    // Stage 1: v = pos*(TABLE_SIZE-1) + half
    assign acc_ext = V_W'(r_acc);
    assign v_next  = (acc_ext <<< IDX_W) - acc_ext + V_HALF;

    // Stage 2: truncate toward zero
    assign v_neg    = -r_v;
    assign mag_next = r_v[V_W-1] ? v_neg[V_W-1:FRACTION_BITS] : r_v[V_W-1:FRACTION_BITS];

    // Stage 4: fold the index back into the table
    assign mag_neg = -r_mag3;
    assign refl_a  = (r_neg3 && (r_rem3 != '0)) ? REFL_W'(REFL_LIM) - r_rem3 : r_rem3;
    assign refl_b  = (refl_a >= REFL_W'(TABLE_SIZE)) ? REFL_W'(REFL_LIM) - refl_a : refl_a;

    always_comb begin
        case (r_mode)
            SPREAD_REFLECT: addr_next = refl_b[IDX_W-1:0];
            SPREAD_REPEAT:  addr_next = r_neg3 ? mag_neg[IDX_W-1:0] : r_mag3[IDX_W-1:0];
            default: begin
                if (r_neg3) begin
                    addr_next = '0;
                end else if (r_mag3 >= MAG_W'(TABLE_SIZE)) begin
                    addr_next = IDX_W'(TABLE_SIZE - 1);
                end else begin
                    addr_next = r_mag3[IDX_W-1:0];
                end
            end
        endcase
    end

    // Pipeline valid and last flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_last <= '0;
        end else begin
            r_vld  <= {r_vld[PIPE_N-2:0], i_cmd.step};
            r_last <= {r_last[PIPE_N-2:0], i_cmd.step && (r_cnt == CNT_W'(1))};
        end
    end

    // Pipeline payload
    always_ff @(posedge i_clk) begin
        r_v    <= v_next;
        r_mag2 <= mag_next;
        r_neg2 <= r_v[V_W-1];
        r_rem3 <= refl_rem(r_mag2);
        r_mag3 <= r_mag2;
        r_neg3 <= r_neg2 && (r_mag2 != '0);
        r_addr <= addr_next;
    end

    // Color table: written by load items, read unconditionally at r_addr
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture && (i_item.opcode == OP_LOAD) && (int'(i_item.entry_index) < TABLE_SIZE))
        begin
            r_table[IDX_W'(i_item.entry_index)] <= i_item.entry_color;
        end
        r_rdata <= r_table[r_addr];
    end

    assign o_result.pixel_color = r_rdata;
    assign o_result.last_pixel  = r_last[PIPE_N-1];
    assign o_strobe             = r_vld[PIPE_N-1];

    assign o_stat.len_zero   = (len_clamped == '0);
    assign o_stat.cnt_last   = (r_cnt == CNT_W'(1));
    assign o_stat.pipe_empty = (r_vld == '0);

    // The final pixel is never directly followed by another
    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.last_pixel) |=> !o_strobe)
        else $error("pixel strobe right after last pixel");

    // Steps only while pixels remain
    a_step_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> (r_cnt != '0))
        else $error("pixel issued with empty counter");

    // Issuing the last pixel empties the counter
    a_last_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[0] && r_last[0]) |-> (r_cnt == '0))
        else $error("last pixel issued with pixels remaining");

endmodule

// File: hdl/linear_gradient_span_fetch_unit.sv
// Top level of the linear gradient span fetch unit: controller plus datapath.
//
// A load item (opcode 0) writes one color table entry in the cycle it is taken
// and leaves the unit free. A span item (opcode 1) keeps busy high until its
// pipeline drains: setup states ST_MUL, ST_SUM and ST_INIT form the start
// position, then one pixel is issued per cycle, limited by the single read
// port of the color table; a zero-length span ends after setup. Each pixel
// passes r_v, r_mag2, r_mag3, r_addr and r_rdata on its way out, and colors
// then follow one per cycle. Results are driven for one cycle with o_strobe
// and cannot be held off by the receiver.
module linear_gradient_span_fetch_unit
    import lgsf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  t_item                i_item,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output t_result              o_result,
    output logic                 o_strobe
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Sequencer
    lgsf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_span  (i_item.opcode == OP_SPAN),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // Arithmetic and table
    lgsf_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_item      (i_item),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_result    (o_result),
        .o_strobe    (o_strobe)
    );

endmodule

// File: verif/tb_linear_gradient_span_fetch_unit.sv
// Self-checking testbench for the linear gradient span fetch unit: random and directed items.
module tb_linear_gradient_span_fetch_unit;
    import lgsf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint POS_HI = (64'sd1 <<< (POS_W - 1)) - 64'sd1;
    localparam longint POS_LO = -POS_HI - 64'sd1;
    localparam logic [MODE_W-1:0] SPREAD_SPARE = 2'd3;
    localparam int LIMIT_CYCLES  = 200000;
    localparam int PHASE_SETTLE  = 16;
    localparam int FINAL_SETTLE  = 80;
    localparam int NO_IDLE_FIRST = 40;
    localparam int NO_IDLE_LAST  = 100;
    localparam int RAND_PHASES   = 8;
    localparam int PHASE_ITEMS   = 20;
    localparam int ITEM_TARGET   = 150;

    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 start       = 1'b0;
    logic                 busy;
    t_item                i_item      = '0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data  = '0;
    t_result              o_result;
    logic                 o_strobe;

    // Predictor state: table contents and programmed gradient
    logic [COLOR_W-1:0] color_mem_model [TABLE_SIZE];
    longint             gain_x_m;
    longint             gain_y_m;
    longint             offset_m;
    logic [MODE_W-1:0]  spread_m;

    // Stimulus side: entries already loaded, so no span reads an unwritten one
    bit      filled_m [TABLE_SIZE];
    int      items_queued = 0;

    t_item   pending_items_q [$];
    t_result expected_pixels_q [$];
    int      items_taken = 0;
    int      err_count   = 0;
    int      cycle_count = 0;

    linear_gradient_span_fetch_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_result    (o_result),
        .o_strobe    (o_strobe)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Saturate to the signed position range
    function automatic longint clamp_pos(input longint v);
        if (v > POS_HI) return POS_HI;
        if (v < POS_LO) return POS_LO;
        return v;
    endfunction

    // Scale a position to a table index, round, then fold it into the table
    function automatic int table_index(input longint pos);
        longint v;
        longint idx;
        longint lim;
        v = pos * longint'(TABLE_SIZE - 1) + (64'sd1 <<< (FRACTION_BITS - 1));
        if (v >= 0) idx = v >>> FRACTION_BITS;
        else        idx = -((-v) >>> FRACTION_BITS);
        if (idx < 0 || idx >= TABLE_SIZE) begin
            if (spread_m == SPREAD_REFLECT) begin
                lim = 2 * longint'(TABLE_SIZE) - 1;
                idx = idx % lim;
                if (idx < 0) idx = idx + lim;
                if (idx >= TABLE_SIZE) idx = lim - idx;
            end else if (spread_m == SPREAD_REPEAT) begin
                idx = idx % longint'(TABLE_SIZE);
                if (idx < 0) idx = idx + TABLE_SIZE;
            end else begin
                idx = (idx < 0) ? 0 : TABLE_SIZE - 1;
            end
        end
        return int'(idx);
    endfunction

    // Start position of a span: floor half of the doubled sum, saturated
    function automatic longint first_pos(input t_item it);
        longint s;
        s = gain_x_m * (2 * longint'(it.start_x) + 1)
          + gain_y_m * (2 * longint'(it.start_y) + 1) + 2 * offset_m;
        return clamp_pos(s >>> 1);
    endfunction

    // Pixel count of a span after the length clamp
    function automatic int span_pixels(input t_item it);
        return (it.span_length > MAX_SPAN) ? MAX_SPAN : int'(it.span_length);
    endfunction

    // Update the table on a load, or queue the colors a span will produce
    task automatic predict_pixels(input t_item it);
        longint  pos;
        int      n;
        t_result r;
        if (it.opcode == OP_LOAD) begin
            color_mem_model[it.entry_index] = it.entry_color;
        end else begin
            pos = first_pos(it);
            n   = span_pixels(it);
            for (int k = 0; k < n; k++) begin
                r.pixel_color = color_mem_model[table_index(pos)];
                r.last_pixel  = (k == n - 1);
                expected_pixels_q.push_back(r);
                pos = clamp_pos(pos + gain_x_m);
            end
        end
    endtask

    // Item with every field random, so unused fields toggle too
    function automatic t_item random_item();
        logic [95:0] raw;
        t_item       it;
        raw = {$urandom(), $urandom(), $urandom()};
        it  = raw[$bits(t_item)-1:0];
        return it;
    endfunction

    function automatic t_item load_item(input int idx, input logic [COLOR_W-1:0] color);
        t_item it;
        it = random_item();
        it.opcode      = OP_LOAD;
        it.entry_index = ENTRY_W'(idx);
        it.entry_color = color;
        return it;
    endfunction

    function automatic t_item span_item(input int x, input int y, input int len);
        t_item it;
        it = random_item();
        it.opcode      = OP_SPAN;
        it.start_x     = COORD_W'(x);
        it.start_y     = COORD_W'(y);
        it.span_length = LEN_W'(len);
        return it;
    endfunction

    // Hand an item to the driver and note which entry a load fills
    function automatic void queue_item(input t_item it);
        pending_items_q.push_back(it);
        items_queued++;
        if (it.opcode == OP_LOAD) filled_m[it.entry_index] = 1'b1;
    endfunction

    // Queue a span, preceded by loads of any entry it reads that is still unwritten
    task automatic queue_span(input int x, input int y, input int len);
        t_item  it;
        longint pos;
        int     n;
        int     idx;
        it  = span_item(x, y, len);
        pos = first_pos(it);
        n   = span_pixels(it);
        for (int k = 0; k < n; k++) begin
            idx = table_index(pos);
            if (!filled_m[idx]) queue_item(load_item(idx, $urandom()));
            pos = clamp_pos(pos + gain_x_m);
        end
        queue_item(it);
    endtask

    // Q15.24 value spread over several magnitudes, extremes included
    function automatic longint rand_fixed();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return longint'($urandom_range(0, 1 << 17)) - (1 << 16);
            2: return longint'($urandom_range(0, 1 << 21)) - (1 << 20);
            3: return longint'($urandom_range(0, 1 << 25)) - (1 << 24);
            4: return longint'($signed(40'({$urandom(), $urandom()})));
            default: return $urandom_range(0, 1) ? POS_HI : POS_LO;
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            CFG_GAIN_X:      gain_x_m = longint'($signed(data));
            CFG_GAIN_Y:      gain_y_m = longint'($signed(data));
            CFG_ORIGIN_OFFS: offset_m = longint'($signed(data));
            CFG_SPREAD_MODE: spread_m = data[MODE_W-1:0];
            default: ;
        endcase
    endtask

    // Program all registers, plus a write to a spare index that must change nothing
    task automatic program_gradient(input longint gx, input longint gy, input longint offs,
                                    input logic [MODE_W-1:0] mode);
        logic [CFG_W-1:0] junk;
        junk = CFG_W'({$urandom(), $urandom()});
        write_reg(CFG_GAIN_X, CFG_W'(gx));
        write_reg(CFG_GAIN_Y, CFG_W'(gy));
        write_reg(CFG_ORIGIN_OFFS, CFG_W'(offs));
        write_reg(CFG_SPREAD_MODE, {junk[CFG_W-1:MODE_W], mode});
        write_reg(CFG_IDX_W'(CFG_SPREAD_MODE + 1 + $urandom_range(0, 3)), ~junk);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Hold the sender until every item is taken and every pixel has come back
    task automatic drain_pixels(input int settle);
        while (pending_items_q.size() != 0 || start || expected_pixels_q.size() != 0)
            @(negedge i_clk);
        repeat (settle) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic log_mismatch(input string what, input t_result want, input t_result got);
        if (err_count < 10)
            $display("%0t: %s: expected color %08h last %0b, got color %08h last %0b",
                     $realtime, what, want.pixel_color, want.last_pixel,
                     got.pixel_color, got.last_pixel);
        err_count++;
    endtask

    // Driver: an item is taken at an edge with start high and busy low
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                predict_pixels(i_item);
                items_taken++;
            end
            if (!start || !busy) begin
                if (pending_items_q.size() != 0 &&
                    ((items_taken >= NO_IDLE_FIRST && items_taken < NO_IDLE_LAST) ||
                     $urandom_range(0, 99) >= 27)) begin
                    start  <= 1'b1;
                    i_item <= pending_items_q.pop_front();
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: each strobed pixel is checked against the oldest expected one
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_strobe !== 1'b0) begin
            if (expected_pixels_q.size() == 0) begin
                log_mismatch("pixel with none expected", '0, o_result);
            end else begin
                want = expected_pixels_q.pop_front();
                if (o_result.pixel_color !== want.pixel_color ||
                    o_result.last_pixel !== want.last_pixel)
                    log_mismatch("pixel mismatch", want, o_result);
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        int r;
        gain_x_m    = 0;
        gain_y_m    = 0;
        offset_m    = 0;
        spread_m    = SPREAD_PAD;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Ramp of a quarter entry per pixel, clamped at the top of the table
        program_gradient(64'sd1 <<< 14, 0, 0, SPREAD_PAD);
        queue_item(load_item(0, '0));
        queue_item(load_item(TABLE_SIZE - 1, '1));
        queue_span(0, 0, 1);
        queue_span(0, 0, MAX_SPAN);
        queue_span(4095, 4095, MAX_SPAN);
        queue_span(17, 3, 0);
        queue_span(40, 0, MAX_SPAN + 1);
        queue_span(1000, 2000, 127);
        queue_item(load_item(128, $urandom()));
        queue_span(63, 0, 3);
        drain_pixels(PHASE_SETTLE);

        // Reflect with a negative step walking back across the table edge
        program_gradient(-(64'sd1 <<< 14), 64'sd1 <<< 13, 0, SPREAD_REFLECT);
        queue_span(0, 0, MAX_SPAN);
        queue_span(2047, 4095, 33);
        queue_span(4095, 0, MAX_SPAN);
        drain_pixels(PHASE_SETTLE);

        // Repeat with extreme registers: saturation of the start and the walk
        program_gradient(POS_HI, POS_LO, POS_LO, SPREAD_REPEAT);
        queue_span(4095, 0, MAX_SPAN);
        queue_span(0, 4095, 5);
        queue_span(0, 0, 2);
        drain_pixels(PHASE_SETTLE);

        // Spare spread code behaves as pad
        program_gradient(POS_LO, POS_HI, POS_HI, SPREAD_SPARE);
        queue_span(0, 4095, MAX_SPAN);
        queue_span(4095, 4095, 9);
        queue_span(5, 7, 0);
        drain_pixels(PHASE_SETTLE);

        // Random phases, each with its own register setting, until the item budget is used
        for (int p = 0; p < RAND_PHASES && items_queued < ITEM_TARGET; p++) begin
            program_gradient(rand_fixed(), rand_fixed(), rand_fixed(),
                             MODE_W'($urandom_range(0, 3)));
            for (int i = 0; i < PHASE_ITEMS && items_queued < ITEM_TARGET; i++) begin
                if ($urandom_range(0, 99) < 30) begin
                    queue_item(load_item($urandom_range(0, TABLE_SIZE - 1), $urandom()));
                end else begin
                    r = $urandom_range(0, 99);
                    queue_span(
                        ($urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(0, 4095)),
                        ($urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(0, 4095)),
                        (r < 5) ? 0 : (r < 10) ? $urandom_range(MAX_SPAN + 1, 127)
                                               : $urandom_range(1, MAX_SPAN));
                end
            end
            drain_pixels(PHASE_SETTLE);
        end

        drain_pixels(FINAL_SETTLE);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: files.f
hdl/lgsf_pkg.sv
hdl/lgsf_ctrl.sv
hdl/lgsf_dpath.sv
hdl/linear_gradient_span_fetch_unit.sv
verif/tb_linear_gradient_span_fetch_unit.sv
